>>> hw/rtl/udr_pkg.sv
// ============================================================================
// udr_pkg : shared types and constants of the diagnostic service responder
// Service and response codes, the register map, the response descriptor that
// travels from the front end through the queue to the byte serializer.
// ============================================================================
`default_nettype none

package udr_pkg;

   // default sizes of the seed and key fields
   localparam int SEED_BYTES_DEF = 4;
   localparam int KEY_BYTES_DEF  = 4;

   // longest response (security seed answer with eight seed bytes)
   localparam int MSG_MAX     = 10;
   localparam int MSG_LEN_W   = $clog2(MSG_MAX + 1);
   localparam int MSG_IDX_W   = $clog2(MSG_MAX);
   localparam int QUEUE_DEPTH = 2;

   // service identifiers
   localparam logic [7:0] SID_SESSION  = 8'h10;
   localparam logic [7:0] SID_RESET    = 8'h11;
   localparam logic [7:0] SID_SECURITY = 8'h27;
   localparam logic [7:0] SID_TESTER   = 8'h3E;

   // session after reset
   localparam logic [2:0] SESSION_DEFAULT = 3'd1;

   // response framing
   localparam logic [7:0] POS_OFFSET   = 8'h40;
   localparam logic [7:0] NEG_MARK     = 8'h7F;
   localparam logic [7:0] SEED_BASE    = 8'hA5;
   localparam logic [7:0] TP_SUPPRESS  = 8'h80;
   localparam logic [7:0] TP_ZERO      = 8'h00;
   localparam int         KEY_FLAG_BIT = 6;
   localparam logic [7:0] RESET_TYPE_MAX   = 8'h05;
   localparam logic [7:0] SESSION_TYPE_MAX = 8'h04;
   localparam logic [3:0] ATTEMPT_SAT  = 4'hF;

   // negative response codes
   localparam logic [7:0] NRC_SNS   = 8'h11;
   localparam logic [7:0] NRC_SFNS  = 8'h12;
   localparam logic [7:0] NRC_LEN   = 8'h13;
   localparam logic [7:0] NRC_KEY   = 8'h35;
   localparam logic [7:0] NRC_ATT   = 8'h36;
   localparam logic [7:0] NRC_DELAY = 8'h37;

   // register map (word index)
   localparam logic [1:0] REG_P2       = 2'd0;
   localparam logic [1:0] REG_P2_STAR  = 2'd1;
   localparam logic [1:0] REG_ATTEMPTS = 2'd2;
   localparam logic [1:0] REG_LOCKOUT  = 2'd3;
   localparam int         CSR_ADDR_W   = 4;

   // register reset values
   localparam logic [15:0] P2_RESET       = 16'd50;
   localparam logic [15:0] P2_STAR_RESET  = 16'd500;
   localparam logic [3:0]  ATTEMPTS_RESET = 4'd3;
   localparam logic [31:0] LOCKOUT_RESET  = 32'd10000;

   typedef struct packed {
      logic [15:0] p2;
      logic [15:0] p2_star;
      logic [3:0]  max_attempts;
      logic [31:0] lockout_ticks;
   } cfg_type;

   typedef logic [MSG_MAX-1:0][7:0] msg_type;

   typedef struct packed {
      msg_type                msg;
      logic [MSG_LEN_W-1:0]   len;
      logic [2:0]             session;
      logic [5:0]             level;
   } rsp_desc_type;

endpackage

`default_nettype wire

>>> hw/rtl/udr_front.sv
// ============================================================================
// udr_front : request decode and diagnostic state
// Takes one request per cycle while the queue has room; updates session,
// security level, attempts and lockout; builds the complete queue response.
// ============================================================================
`default_nettype none

module udr_front #(
   parameter int SEED_BYTES = udr_pkg::SEED_BYTES_DEF,
   parameter int KEY_BYTES  = udr_pkg::KEY_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  udr_pkg::cfg_type           cfg,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  action,
   input  wire logic [7:0]            service_id,
   input  wire logic [7:0]            sub_function,
   input  wire logic [31:0]           key_value,
   input  wire logic [7:0]            request_length,
   input  wire logic                  queue_full,
   output logic                       push,
   output udr_pkg::rsp_desc_type      push_desc
);

   logic [2:0]  session_ff, session_in;
   logic [5:0]  level_ff, level_in;
   logic [3:0]  failed_ff, failed_in;
   logic        lock_active_ff, lock_active_in;
   logic [31:0] lock_count_ff, lock_count_in;

   logic                            accept;
   logic                            known;
   logic                            key_ok;
   logic [63:0]                     key_ext;
   udr_pkg::msg_type                msg;
   logic [udr_pkg::MSG_LEN_W-1:0]   len;

   function automatic udr_pkg::msg_type negative(input logic [7:0] sid,
                                                 input logic [7:0] nrc);
      udr_pkg::msg_type m;
      m    = '0;
      m[0] = udr_pkg::NEG_MARK;
      m[1] = sid;
      m[2] = nrc;
      return m;
   endfunction

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign key_ext   = {32'b0, key_value};

   // key bytes compare in parallel, first key byte is the most significant
   always_comb begin
      key_ok = 1'b1;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (key_ext[(KEY_BYTES - 1 - i) * 8 +: 8] != 8'(udr_pkg::SEED_BASE + i)) begin
            key_ok = 1'b0;
         end
      end
   end

   assign known = (service_id == udr_pkg::SID_SESSION)  ||
                  (service_id == udr_pkg::SID_RESET)    ||
                  (service_id == udr_pkg::SID_SECURITY) ||
                  (service_id == udr_pkg::SID_TESTER);

   always_comb begin
      session_in     = session_ff;
      level_in       = level_ff;
      failed_in      = failed_ff;
      lock_active_in = lock_active_ff;
      lock_count_in  = lock_count_ff;
      msg            = '0;
      len            = '0;

      if (action) begin
         // time tick: lockout countdown only
         if (lock_active_ff) begin
            if (lock_count_ff > 32'd1) begin
               lock_count_in = lock_count_ff - 32'd1;
            end else begin
               lock_count_in  = '0;
               lock_active_in = 1'b0;
               failed_in      = '0;
            end
         end
      end else if (!known) begin
         msg = negative(service_id, udr_pkg::NRC_SNS);
         len = udr_pkg::MSG_LEN_W'(3);
      end else if (request_length == 8'd0) begin
         msg = negative(service_id, udr_pkg::NRC_LEN);
         len = udr_pkg::MSG_LEN_W'(3);
      end else begin
         unique case (service_id)
            udr_pkg::SID_SESSION: begin
               if (sub_function >= 8'd1 && sub_function <= udr_pkg::SESSION_TYPE_MAX) begin
                  session_in = sub_function[2:0];
                  msg[0] = service_id + udr_pkg::POS_OFFSET;
                  msg[1] = sub_function;
                  msg[2] = cfg.p2[15:8];
                  msg[3] = cfg.p2[7:0];
                  msg[4] = cfg.p2_star[15:8];
                  msg[5] = cfg.p2_star[7:0];
                  len    = udr_pkg::MSG_LEN_W'(6);
               end else begin
                  msg = negative(service_id, udr_pkg::NRC_SFNS);
                  len = udr_pkg::MSG_LEN_W'(3);
               end
            end
            udr_pkg::SID_RESET: begin
               if (sub_function >= 8'd1 && sub_function <= udr_pkg::RESET_TYPE_MAX) begin
                  msg[0] = service_id + udr_pkg::POS_OFFSET;
                  msg[1] = sub_function;
                  len    = udr_pkg::MSG_LEN_W'(2);
               end else begin
                  msg = negative(service_id, udr_pkg::NRC_SFNS);
                  len = udr_pkg::MSG_LEN_W'(3);
               end
            end
            udr_pkg::SID_TESTER: begin
               if (sub_function == udr_pkg::TP_ZERO) begin
                  msg[0] = service_id + udr_pkg::POS_OFFSET;
                  msg[1] = sub_function;
                  len    = udr_pkg::MSG_LEN_W'(2);
               end else if (sub_function != udr_pkg::TP_SUPPRESS) begin
                  msg = negative(service_id, udr_pkg::NRC_SFNS);
                  len = udr_pkg::MSG_LEN_W'(3);
               end
            end
            udr_pkg::SID_SECURITY: begin
               if (!sub_function[udr_pkg::KEY_FLAG_BIT]) begin
                  // seed request
                  if (lock_active_ff) begin
                     msg = negative(service_id, udr_pkg::NRC_DELAY);
                     len = udr_pkg::MSG_LEN_W'(3);
                  end else if (failed_ff >= cfg.max_attempts) begin
                     msg            = negative(service_id, udr_pkg::NRC_ATT);
                     len            = udr_pkg::MSG_LEN_W'(3);
                     lock_active_in = 1'b1;
                     lock_count_in  = cfg.lockout_ticks;
                  end else begin
                     msg[0] = service_id + udr_pkg::POS_OFFSET;
                     msg[1] = sub_function;
                     for (int i = 0; i < SEED_BYTES; i++) begin
                        msg[2 + i] = 8'(udr_pkg::SEED_BASE + i);
                     end
                     len = udr_pkg::MSG_LEN_W'(2 + SEED_BYTES);
                  end
               end else if ({1'b0, request_length} < 9'(KEY_BYTES + 1)) begin
                  msg = negative(service_id, udr_pkg::NRC_LEN);
                  len = udr_pkg::MSG_LEN_W'(3);
               end else if (key_ok) begin
                  level_in  = sub_function[5:0];
                  failed_in = '0;
                  msg[0]    = service_id + udr_pkg::POS_OFFSET;
                  msg[1]    = sub_function;
                  len       = udr_pkg::MSG_LEN_W'(2);
               end else begin
                  if (failed_ff < udr_pkg::ATTEMPT_SAT) begin
                     failed_in = failed_ff + 4'd1;
                  end
                  msg = negative(service_id, udr_pkg::NRC_KEY);
                  len = udr_pkg::MSG_LEN_W'(3);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign push              = accept && !action && (len != '0);
   assign push_desc.msg     = msg;
   assign push_desc.len     = len;
   assign push_desc.session = session_in;
   assign push_desc.level   = level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         session_ff     <= udr_pkg::SESSION_DEFAULT;
         level_ff       <= '0;
         failed_ff      <= '0;
         lock_active_ff <= 1'b0;
         lock_count_ff  <= '0;
      end else if (accept) begin
         session_ff     <= session_in;
         level_ff       <= level_in;
         failed_ff      <= failed_in;
         lock_active_ff <= lock_active_in;
         lock_count_ff  <= lock_count_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/udr_queue.sv
// ============================================================================
// udr_queue : response descriptor queue
// Small FIFO between the request decoder and the byte serializer.
// ============================================================================
`default_nettype none

module udr_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  udr_pkg::rsp_desc_type  push_desc,
   output logic                   full,
   input  wire logic              pop,
   output logic                   empty,
   output udr_pkg::rsp_desc_type  head
);

   localparam int DEPTH = udr_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   udr_pkg::rsp_desc_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/udr_back.sv
// ============================================================================
// udr_back : response byte serializer
// Moves the head descriptor one byte per ready cycle into the output register.
// ============================================================================
`default_nettype none

module udr_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  udr_pkg::rsp_desc_type  head,
   input  wire logic              empty,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_byte,
   output logic                   rsp_last,
   output logic [2:0]             rsp_session,
   output logic [5:0]             rsp_level
);

   logic [udr_pkg::MSG_IDX_W-1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [2:0] session_ff, session_in;
   logic [5:0] level_ff, level_in;
   logic       load;
   logic       at_end;

   assign load   = !empty && (!valid_ff || rsp_ready);
   assign at_end = (udr_pkg::MSG_LEN_W'(idx_ff) == head.len - udr_pkg::MSG_LEN_W'(1));

   always_comb begin
      idx_in     = idx_ff;
      valid_in   = valid_ff && !rsp_ready;
      byte_in    = byte_ff;
      last_in    = last_ff;
      session_in = session_ff;
      level_in   = level_ff;
      pop        = 1'b0;
      if (load) begin
         valid_in   = 1'b1;
         byte_in    = head.msg[idx_ff];
         last_in    = at_end;
         session_in = head.session;
         level_in   = head.level;
         if (at_end) begin
            idx_in = '0;
            pop    = 1'b1;
         end else begin
            idx_in = idx_ff + udr_pkg::MSG_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      last_ff    <= last_in;
      session_ff <= session_in;
      level_ff   <= level_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_byte    = byte_ff;
   assign rsp_last    = last_ff;
   assign rsp_session = session_ff;
   assign rsp_level   = level_ff;

endmodule

`default_nettype wire

>>> hw/rtl/uds_diagnostic_service_responder.sv
// ============================================================================
// uds_diagnostic_service_responder : small diagnostic server
// Answers session control, ECU reset, security access and tester present,
// keeps session, security level, failed-key counter and lockout timer.
// ============================================================================
// Each request on the req_ stream is either a diagnostic request or one time
// tick (req_tuser high). The front end takes one request per clock while the
// queue has room, applies it to the session/security state and hands the
// finished response to a two-entry queue; the back end sends it out one byte
// per clock while rsp_tready is high on the rsp_ stream, tlast on the final
// byte. A response has 2, 3, 6 or 2+SEED_BYTES bytes (at most 10), and the
// byte serializer sets the sustained rate: requests keep being taken while
// the queue has room, so a steady mix runs at the pace of its response bytes.
// Ticks and suppressed tester-present requests give no bytes. Registers sit
// on the csr_ port at byte addresses 0, 4, 8, 12.
// ============================================================================
`default_nettype none

module uds_diagnostic_service_responder #(
   parameter int SEED_BYTES = udr_pkg::SEED_BYTES_DEF,
   parameter int KEY_BYTES  = udr_pkg::KEY_BYTES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request stream
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [7:0] service_id, [15:8] sub_function, [47:16] key_value,
   // [55:48] request_length
   input  wire logic [55:0]                    req_tdata,
   // [0] action (1 = time tick)
   input  wire logic                           req_tuser,
   // response stream
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [7:0] resp_byte, [10:8] active_session, [16:11] unlocked_level,
   // [23:17] zero
   output logic [23:0]                         rsp_tdata,
   output logic                                rsp_tlast,
   // register port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [udr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   udr_pkg::cfg_type      cfg_ff, cfg_in;
   udr_pkg::rsp_desc_type push_desc, head;
   logic                  push, pop, full, empty;
   logic                  csr_write;
   logic [2:0]            rsp_session;
   logic [5:0]            rsp_level;
   logic [7:0]            rsp_byte;

   // ---------------------------------------------------------------- registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            udr_pkg::REG_P2:       cfg_in.p2            = csr_pwdata[15:0];
            udr_pkg::REG_P2_STAR:  cfg_in.p2_star       = csr_pwdata[15:0];
            udr_pkg::REG_ATTEMPTS: cfg_in.max_attempts  = csr_pwdata[3:0];
            udr_pkg::REG_LOCKOUT:  cfg_in.lockout_ticks = csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         udr_pkg::REG_P2:       csr_prdata = {16'b0, cfg_ff.p2};
         udr_pkg::REG_P2_STAR:  csr_prdata = {16'b0, cfg_ff.p2_star};
         udr_pkg::REG_ATTEMPTS: csr_prdata = {28'b0, cfg_ff.max_attempts};
         udr_pkg::REG_LOCKOUT:  csr_prdata = cfg_ff.lockout_ticks;
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.p2            <= udr_pkg::P2_RESET;
         cfg_ff.p2_star       <= udr_pkg::P2_STAR_RESET;
         cfg_ff.max_attempts  <= udr_pkg::ATTEMPTS_RESET;
         cfg_ff.lockout_ticks <= udr_pkg::LOCKOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------- front end
   udr_front #(
      .SEED_BYTES (SEED_BYTES),
      .KEY_BYTES  (KEY_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .action         (req_tuser),
      .service_id     (req_tdata[7:0]),
      .sub_function   (req_tdata[15:8]),
      .key_value      (req_tdata[47:16]),
      .request_length (req_tdata[55:48]),
      .queue_full     (full),
      .push           (push),
      .push_desc      (push_desc)
   );

   // ---------------------------------------------------------------- queue
   udr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   // ---------------------------------------------------------------- back end
   udr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (empty),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_byte    (rsp_byte),
      .rsp_last    (rsp_tlast),
      .rsp_session (rsp_session),
      .rsp_level   (rsp_level)
   );

   assign rsp_tdata = {7'b0, rsp_level, rsp_session, rsp_byte};

endmodule

`default_nettype wire

>>> hw/rtl/udr_checker.sv
// ============================================================================
// udr_checker : port-level checks of the diagnostic responder
// Watches the response stream and register port over time.
// ============================================================================
`default_nettype none

module udr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        csr_pready
);

   logic first_ff;
   logic [7:0] rb;

   assign rb = rsp_tdata[7:0];

   // marks the opening byte of a response
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else if (rsp_tvalid && rsp_tready) begin
         first_ff <= rsp_tlast;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_session_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10:8] >= 3'd1) && (rsp_tdata[10:8] <= 3'd4))
      else $error("session out of range");

   a_first_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && first_ff |->
         (rb == udr_pkg::NEG_MARK) ||
         (rb == udr_pkg::SID_SESSION + udr_pkg::POS_OFFSET) ||
         (rb == udr_pkg::SID_RESET + udr_pkg::POS_OFFSET) ||
         (rb == udr_pkg::SID_SECURITY + udr_pkg::POS_OFFSET) ||
         (rb == udr_pkg::SID_TESTER + udr_pkg::POS_OFFSET))
      else $error("response opens with an unknown byte");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("register port not ready");

endmodule

bind uds_diagnostic_service_responder udr_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);

`default_nettype wire

>>> dv/uds_diagnostic_service_responder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uds_diagnostic_service_responder_test : self-checking bench for the responder
// Drives diagnostic requests and time ticks on the req_ stream and changes the
// timing and security registers over the csr_ port between phases. A
// scoreboard tracks session, security level, failed-key count and lockout on
// its own, predicts every response byte and compares each byte that leaves
// the rsp_ stream with the oldest prediction.
// ----------------------------------------------------------------------------

module uds_diagnostic_service_responder_test;
   import udr_pkg::*;

   localparam int          KEY_BYTES       = KEY_BYTES_DEF;
   localparam int          SEED_BYTES      = SEED_BYTES_DEF;
   // the one key that unlocks: the seed pattern sent back unchanged
   localparam logic [31:0] GOOD_KEY        = {SEED_BASE, 8'(SEED_BASE + 1),
                                              8'(SEED_BASE + 2), 8'(SEED_BASE + 3)};
   localparam int          DRAIN_CYCLES    = 16;
   localparam int          PHASES          = 5;
   localparam int          ITEMS_PER_PHASE = 64;

   // one request as it travels on req_tuser / req_tdata
   typedef struct packed {
      logic        tick;
      logic [7:0]  sid;
      logic [7:0]  sub;
      logic [31:0] key;
      logic [7:0]  len;
   } diag_req_t;

   // one response byte with the state seen beside it
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [2:0] session;
      logic [5:0] level;
   } resp_byte_t;

   // -------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the server state and registers, turns
   // each accepted request into the bytes it must produce, checks the bytes.
   // -------------------------------------------------------------------------
   class diag_server_tracker;
      cfg_type     regs;
      logic [2:0]  session;
      logic [5:0]  level;
      logic [3:0]  attempts;
      logic        locked;
      logic [31:0] lock_count;
      resp_byte_t  expected_bytes[$];
      int          mismatches;

      function new();
         regs.p2            = P2_RESET;
         regs.p2_star       = P2_STAR_RESET;
         regs.max_attempts  = ATTEMPTS_RESET;
         regs.lockout_ticks = LOCKOUT_RESET;
         session            = SESSION_DEFAULT;
         level              = '0;
         attempts           = '0;
         locked             = 1'b0;
         lock_count         = '0;
         mismatches         = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_P2:       regs.p2            = value[15:0];
            REG_P2_STAR:  regs.p2_star       = value[15:0];
            REG_ATTEMPTS: regs.max_attempts  = value[3:0];
            REG_LOCKOUT:  regs.lockout_ticks = value;
            default: ;
         endcase
      endfunction

      function void take_request(diag_req_t r);
         logic [7:0] msg[$];
         logic [7:0] key_byte;
         logic       key_ok;
         int         shift;
         // a tick only runs the lockout timer down
         if (r.tick) begin
            if (locked) begin
               if (lock_count > 1) begin
                  lock_count--;
               end else begin
                  lock_count = '0;
                  locked     = 1'b0;
                  attempts   = '0;
               end
            end
            return;
         end
         if (!(r.sid inside {SID_SESSION, SID_RESET, SID_SECURITY, SID_TESTER})) begin
            msg = '{NEG_MARK, r.sid, NRC_SNS};
         end else if (r.len == 0) begin
            msg = '{NEG_MARK, r.sid, NRC_LEN};
         end else begin
            case (r.sid)
               SID_SESSION: begin
                  if (r.sub >= 1 && r.sub <= SESSION_TYPE_MAX) begin
                     session = r.sub[2:0];
                     msg = '{SID_SESSION + POS_OFFSET, r.sub, regs.p2[15:8], regs.p2[7:0],
                             regs.p2_star[15:8], regs.p2_star[7:0]};
                  end else begin
                     msg = '{NEG_MARK, r.sid, NRC_SFNS};
                  end
               end
               SID_RESET: begin
                  if (r.sub >= 1 && r.sub <= RESET_TYPE_MAX)
                     msg = '{SID_RESET + POS_OFFSET, r.sub};
                  else
                     msg = '{NEG_MARK, r.sid, NRC_SFNS};
               end
               SID_TESTER: begin
                  if (r.sub == TP_ZERO)
                     msg = '{SID_TESTER + POS_OFFSET, r.sub};
                  else if (r.sub != TP_SUPPRESS)
                     msg = '{NEG_MARK, r.sid, NRC_SFNS};
               end
               default: begin
                  if (!r.sub[KEY_FLAG_BIT]) begin
                     // seed request
                     if (locked) begin
                        msg = '{NEG_MARK, SID_SECURITY, NRC_DELAY};
                     end else if (attempts >= regs.max_attempts) begin
                        msg        = '{NEG_MARK, SID_SECURITY, NRC_ATT};
                        locked     = 1'b1;
                        lock_count = regs.lockout_ticks;
                     end else begin
                        msg = '{SID_SECURITY + POS_OFFSET, r.sub};
                        for (int i = 0; i < SEED_BYTES; i++)
                           msg.push_back(8'(SEED_BASE + i));
                     end
                  end else if (r.len < KEY_BYTES + 1) begin
                     msg = '{NEG_MARK, SID_SECURITY, NRC_LEN};
                  end else begin
                     // key check, first key byte in the top bits
                     key_ok = 1'b1;
                     for (int i = 0; i < KEY_BYTES; i++) begin
                        shift    = (KEY_BYTES - 1 - i) * 8;
                        key_byte = (shift < 32) ? 8'(r.key >> shift) : 8'h00;
                        if (key_byte != 8'(SEED_BASE + i))
                           key_ok = 1'b0;
                     end
                     if (key_ok) begin
                        level    = r.sub[5:0];
                        attempts = '0;
                        msg      = '{SID_SECURITY + POS_OFFSET, r.sub};
                     end else begin
                        if (attempts != ATTEMPT_SAT)
                           attempts++;
                        msg = '{NEG_MARK, SID_SECURITY, NRC_KEY};
                     end
                  end
               end
            endcase
         end
         while (msg.size() > MSG_MAX)
            msg.pop_back();
         // state after the request rides along on every byte
         foreach (msg[k])
            expected_bytes.push_back('{data: msg[k], last: (k == msg.size() - 1),
                                       session: session, level: level});
      endfunction

      function void check_byte(resp_byte_t got);
         resp_byte_t want;
         if (expected_bytes.size() == 0) begin
            mismatches++;
            $display({"%0t: unexpected response byte: expected none, ",
                      "got byte %h last %b session %0d level %0d"},
                     $time, got.data, got.last, got.session, got.level);
            return;
         end
         want = expected_bytes.pop_front();
         if (got !== want) begin
            mismatches++;
            $display({"%0t: response mismatch: expected byte %h last %b session %0d ",
                      "level %0d, got byte %h last %b session %0d level %0d"},
                     $time, want.data, want.last, want.session, want.level,
                     got.data, got.last, got.session, got.level);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block hookup; every input starts at a known value
   // -------------------------------------------------------------------------
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata   = '0;   // [7:0] sid, [15:8] sub, [47:16] key, [55:48] length
   logic        req_tuser   = 1'b0; // [0] time tick
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;          // [7:0] byte, [10:8] session, [16:11] level, [23:17] zero
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   diag_server_tracker tracker;

   // sender burst bookkeeping
   int burst_left;
   int phase_sent;
   // receiver stall pattern
   int stall_mode;
   int mode_left;
   int stall_cycle;

   uds_diagnostic_service_responder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: picks a stall mode for a stretch of cycles, from always ready
   // through random stalls to a fixed on/off pattern.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(16, 128);
      end else begin
         mode_left--;
      end
      stall_cycle++;
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         2:       rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= stall_cycle[2];
      endcase
   end

   // Monitor: bytes are checked before the request of the same edge is noted,
   // since a byte leaving now can only belong to an older request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            tracker.check_byte(resp_byte_t'({rsp_tdata[7:0], rsp_tlast, rsp_tdata[10:8],
                                             rsp_tdata[16:11]}));
         if (req_tvalid && req_tready)
            tracker.take_request(diag_req_t'({req_tuser, req_tdata[7:0], req_tdata[15:8],
                                              req_tdata[47:16], req_tdata[55:48]}));
      end
   end

   function automatic diag_req_t diag_request(logic tick, logic [7:0] sid, logic [7:0] sub,
                                              logic [31:0] key, logic [7:0] len);
      return '{tick: tick, sid: sid, sub: sub, key: key, len: len};
   endfunction

   // mostly the shortest legal length or up to two more, now and then empty, short or any length
   function automatic logic [7:0] pick_len(int lo);
      case ($urandom_range(0, 19))
         0:       return 8'h00;
         1:       return 8'($urandom);
         2:       return 8'($urandom_range(1, KEY_BYTES));
         default: return 8'(lo + $urandom_range(0, 2));
      endcase
   endfunction

   // One request: held until accepted. At the end of a burst the sender drops
   // valid for a random gap and draws the next burst length.
   task automatic send_request(diag_req_t r);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= r.tick;
      req_tdata  <= {r.len, r.key, r.sub, r.sid};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      phase_sent++;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // Hold off until every predicted byte is out, then give trailing ticks and
   // suppressed requests time to clear the front end.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.expected_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      tracker.set_register(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // registers change only with the block idle
   task automatic configure(logic [15:0] p2, logic [15:0] p2_star, logic [3:0] max_att,
                            logic [31:0] lock_ticks);
      drain();
      csr_write(REG_P2, 32'(p2));
      csr_write(REG_P2_STAR, 32'(p2_star));
      csr_write(REG_ATTEMPTS, 32'(max_att));
      csr_write(REG_LOCKOUT, lock_ticks);
   endtask

   // Random traffic: mostly seed/key exchanges and legal service calls with
   // random content, plus tick runs, key floods and raw noise.
   task automatic random_scenario();
      int          pick;
      logic [7:0]  sub;
      logic [31:0] key;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         sub = 8'($urandom);
         sub[KEY_FLAG_BIT] = 1'b0;
         send_request(diag_request(1'b0, SID_SECURITY, sub, $urandom, pick_len(1)));
         if ($urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 4) == 0)
               sub = 8'($urandom);
            sub[KEY_FLAG_BIT] = 1'b1;
            case ($urandom_range(0, 4))
               0:       key = $urandom;
               1:       key = GOOD_KEY ^ (32'd1 << $urandom_range(0, 31));
               default: key = GOOD_KEY;
            endcase
            send_request(diag_request(1'b0, SID_SECURITY, sub, key, pick_len(KEY_BYTES + 1)));
         end
      end else if (pick < 50) begin
         repeat ($urandom_range(1, 8))
            send_request(diag_request(1'b1, 8'($urandom), 8'($urandom), $urandom,
                                      8'($urandom)));
      end else if (pick < 62) begin
         sub = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
         send_request(diag_request(1'b0, SID_SESSION, sub, $urandom, pick_len(1)));
      end else if (pick < 70) begin
         sub = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
         send_request(diag_request(1'b0, SID_RESET, sub, $urandom, pick_len(1)));
      end else if (pick < 80) begin
         case ($urandom_range(0, 2))
            0:       sub = TP_ZERO;
            1:       sub = TP_SUPPRESS;
            default: sub = 8'($urandom);
         endcase
         send_request(diag_request(1'b0, SID_TESTER, sub, $urandom, pick_len(1)));
      end else if (pick < 85) begin
         // wrong keys in a row, sometimes enough to saturate the attempt counter
         repeat ($urandom_range(4, 20)) begin
            sub = 8'($urandom);
            sub[KEY_FLAG_BIT] = 1'b1;
            send_request(diag_request(1'b0, SID_SECURITY, sub, GOOD_KEY ^ 32'($urandom | 1),
                                      pick_len(KEY_BYTES + 1)));
         end
      end else begin
         send_request(diag_request($urandom_range(0, 3) == 0, 8'($urandom), 8'($urandom),
                                   $urandom, 8'($urandom)));
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      tracker     = new();
      burst_left  = 1;
      phase_sent  = 0;
      stall_mode  = 0;
      mode_left   = 0;
      stall_cycle = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset register values
      send_request(diag_request(1'b0, SID_TESTER, TP_ZERO, 32'h0, 8'd1));
      send_request(diag_request(1'b0, SID_TESTER, TP_SUPPRESS, 32'h0, 8'd1)); // no answer
      send_request(diag_request(1'b0, SID_TESTER, 8'h05, 32'h0, 8'd2));
      send_request(diag_request(1'b0, SID_SESSION, 8'h03, 32'h0, 8'd1));
      send_request(diag_request(1'b0, SID_SESSION, 8'h00, 32'h0, 8'd1));
      send_request(diag_request(1'b0, SID_SESSION, 8'h01, 32'h0, 8'd0));    // empty request
      send_request(diag_request(1'b0, SID_RESET, RESET_TYPE_MAX, 32'h0, 8'hFF));
      send_request(diag_request(1'b0, SID_RESET, 8'h06, 32'h0, 8'd1));
      send_request(diag_request(1'b0, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'd0));  // unknown service
      send_request(diag_request(1'b0, 8'h00, 8'h00, 32'hFFFF_FFFF, 8'hFF));
      send_request(diag_request(1'b0, SID_SECURITY, 8'h01, 32'h0, 8'd1));   // seed
      send_request(diag_request(1'b0, SID_SECURITY, 8'h41, GOOD_KEY, 8'd4)); // key too short
      send_request(diag_request(1'b0, SID_SECURITY, 8'h42, 32'h0, 8'd5));   // wrong key
      send_request(diag_request(1'b0, SID_SECURITY, 8'h7F, GOOD_KEY, 8'hFF)); // top level

      // directed, short lockout: two misses lock, three ticks release
      configure(16'hFFFF, 16'h0001, 4'd2, 32'd3);
      send_request(diag_request(1'b0, SID_SESSION, SESSION_TYPE_MAX, 32'h0, 8'd1));
      send_request(diag_request(1'b0, SID_SECURITY, 8'h43, 32'hFFFF_FFFF, 8'd5));
      send_request(diag_request(1'b0, SID_SECURITY, 8'h43, GOOD_KEY ^ 32'd1, 8'd5));
      send_request(diag_request(1'b0, SID_SECURITY, 8'h03, 32'h0, 8'd1));   // starts lockout
      send_request(diag_request(1'b0, SID_SECURITY, 8'h03, 32'h0, 8'd1));   // delay refused
      send_request(diag_request(1'b0, SID_SECURITY, 8'h41, GOOD_KEY, 8'd5)); // key while locked
      repeat (3)
         send_request(diag_request(1'b1, 8'h00, 8'h00, 32'h0, 8'h00));
      send_request(diag_request(1'b0, SID_SECURITY, 8'h05, 32'h0, 8'd1));
      send_request(diag_request(1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF)); // idle tick

      // random phases; the last one never leaves lockout and keeps it that way
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: configure(16'($urandom), 16'($urandom), 4'd1, 32'd1);
            1: configure(16'h0000, 16'hFFFF, ATTEMPT_SAT, 32'd5);
            2: configure(16'($urandom), 16'($urandom), 4'($urandom_range(2, 4)), 32'd0);
            3: configure(16'hFFFF, 16'h0000, 4'($urandom_range(1, 15)), $urandom_range(1, 40));
            default: configure(16'($urandom), 16'($urandom), 4'd0, 32'hFFFF_FFFF);
         endcase
         phase_sent = 0;
         while (phase_sent < ITEMS_PER_PHASE)
            random_scenario();
      end

      drain();
      if (tracker.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #(10_000_000);
      $display("status: fail");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/udr_pkg.sv
hw/rtl/udr_front.sv
hw/rtl/udr_queue.sv
hw/rtl/udr_back.sv
hw/rtl/uds_diagnostic_service_responder.sv
hw/rtl/udr_checker.sv
dv/uds_diagnostic_service_responder_test.sv
